// ===== sv/tctwm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tctwm_pkg
// Shared widths and channel indexes for the two-channel trimmed window mean.
// ----------------------------------------------------------------------------
package tctwm_pkg;

	localparam int unsigned SAMPLE_W   = 16;
	localparam int unsigned SUM_W      = 22;
	localparam int unsigned DROP_W     = SAMPLE_W + 1;
	localparam int unsigned CNT_W      = 6;
	localparam int unsigned TRIM_COUNT = 2;

	localparam int unsigned NCH = 2;

	typedef enum logic {
		CH_TVOC = 1'b0,
		CH_ECO2 = 1'b1
	} chan_t;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [SUM_W-1:0]    sum_t;
	typedef logic [DROP_W-1:0]   drop_t;
	typedef logic [CNT_W-1:0]    count_t;

endpackage

// ===== sv/two_channel_trimmed_window_mean_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_channel_trimmed_window_mean_unit
// Per-channel sum, min and max over WINDOW sample pairs; on the last pair of
// a window drops one min and one max and divides by WINDOW-2 (truncating).
//
//   channel   handshake                  payload
//   sample    sample_valid/sample_ready  tvoc_sample, eco2_sample
//   mean      mean_valid/mean_ready      tvoc_mean, eco2_mean
//
// One item is taken per cycle while sample_ready is high; the accumulator
// update is one add and compare. A window's means pass from stage 1 through
// trim subtract, reciprocal multiply and remainder fix-up into the output.
// Reset clears the window state and all stage valids.
// A stalled mean only blocks the closing item of a later window, and only
// once all four result stages are full.
// ----------------------------------------------------------------------------
module two_channel_trimmed_window_mean_unit #(
	parameter int unsigned WINDOW = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         sample_valid,
	output logic                         sample_ready,
	input  logic [tctwm_pkg::SAMPLE_W-1:0] tvoc_sample,
	input  logic [tctwm_pkg::SAMPLE_W-1:0] eco2_sample,
	output logic                         mean_valid,
	input  logic                         mean_ready,
	output logic [tctwm_pkg::SAMPLE_W-1:0] tvoc_mean,
	output logic [tctwm_pkg::SAMPLE_W-1:0] eco2_mean
);

	import tctwm_pkg::*;

	localparam int unsigned DIVISOR     = (WINDOW > TRIM_COUNT) ? WINDOW - TRIM_COUNT : 1;
	localparam int unsigned RECIP_SHIFT = SUM_W + 1;
	localparam int unsigned RECIP_W     = SUM_W + 2;
	localparam int unsigned PROD_W      = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'((64'd1 << RECIP_SHIFT) / DIVISOR);
	localparam sum_t   DIV_V    = SUM_W'(DIVISOR);
	localparam count_t WIN_LAST = CNT_W'(WINDOW - 1);

	// window state
	count_t  count_q;
	sum_t    sum_q [NCH];
	sample_t min_q [NCH];
	sample_t max_q [NCH];

	sample_t samp     [NCH];
	sample_t min_next [NCH];
	sample_t max_next [NCH];
	sum_t    sum_next [NCH];
	drop_t   drop_next[NCH];

	// result pipeline
	logic    v_s1, v_s2, v_s3;
	sum_t    sum_s1  [NCH];
	drop_t   drop_s1 [NCH];
	sum_t    rest_s2 [NCH];
	sum_t    rest_s3 [NCH];
	sum_t    qest_s3 [NCH];

	sum_t              rest_c [NCH];
	logic [PROD_W-1:0] prod_c [NCH];
	sum_t              rem_c  [NCH];
	sum_t              quot_c [NCH];

	logic out_free, s3_free, s2_free, s1_free;
	logic last_sample, accept, close;

	assign samp[CH_TVOC] = tvoc_sample;
	assign samp[CH_ECO2] = eco2_sample;

	assign out_free = !mean_valid || mean_ready;
	assign s3_free  = !v_s3 || out_free;
	assign s2_free  = !v_s2 || s3_free;
	assign s1_free  = !v_s1 || s2_free;

	assign last_sample  = (count_q >= WIN_LAST);
	assign sample_ready = !last_sample || s1_free;
	assign accept       = sample_valid && sample_ready;
	assign close        = accept && last_sample;

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			min_next[c]  = (samp[c] < min_q[c]) ? samp[c] : min_q[c];
			max_next[c]  = (samp[c] > max_q[c]) ? samp[c] : max_q[c];
			sum_next[c]  = sum_q[c] + SUM_W'(samp[c]);
			drop_next[c] = DROP_W'(min_next[c]) + DROP_W'(max_next[c]);
		end
	end

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			rest_c[c] = (sum_s1[c] >= SUM_W'(drop_s1[c])) ?
				sum_s1[c] - SUM_W'(drop_s1[c]) : '0;
			prod_c[c] = PROD_W'(rest_s2[c]) * PROD_W'(RECIP);
			rem_c[c]  = rest_s3[c] - SUM_W'(qest_s3[c] * DIV_V);
			quot_c[c] = (rem_c[c] >= DIV_V) ? qest_s3[c] + SUM_W'(1) : qest_s3[c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int c = 0; c < NCH; c++) begin
				sum_q[c] <= '0;
				min_q[c] <= '1;
				max_q[c] <= '0;
			end
		end else if (accept) begin
			if (last_sample) begin
				count_q <= '0;
				for (int c = 0; c < NCH; c++) begin
					sum_q[c] <= '0;
					min_q[c] <= '1;
					max_q[c] <= '0;
				end
			end else begin
				count_q <= count_q + CNT_W'(1);
				for (int c = 0; c < NCH; c++) begin
					sum_q[c] <= sum_next[c];
					min_q[c] <= min_next[c];
					max_q[c] <= max_next[c];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			mean_valid <= 1'b0;
		end else begin
			if (s1_free)  v_s1       <= close;
			if (s2_free)  v_s2       <= v_s1;
			if (s3_free)  v_s3       <= v_s2;
			if (out_free) mean_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (close) begin
			for (int c = 0; c < NCH; c++) begin
				sum_s1[c]  <= sum_next[c];
				drop_s1[c] <= drop_next[c];
			end
		end
		if (v_s1 && s2_free) begin
			for (int c = 0; c < NCH; c++) begin
				rest_s2[c] <= rest_c[c];
			end
		end
		if (v_s2 && s3_free) begin
			for (int c = 0; c < NCH; c++) begin
				rest_s3[c] <= rest_s2[c];
				qest_s3[c] <= prod_c[c][RECIP_SHIFT +: SUM_W];
			end
		end
		if (v_s3 && out_free) begin
			tvoc_mean <= quot_c[CH_TVOC][SAMPLE_W-1:0];
			eco2_mean <= quot_c[CH_ECO2][SAMPLE_W-1:0];
		end
	end

endmodule

// ===== sv/tctwm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tctwm_checker
// Port-level checks for the trimmed window mean unit, bound to the top level.
// ----------------------------------------------------------------------------
module tctwm_checker #(
	parameter int unsigned WINDOW = 10
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           sample_valid,
	input logic                           sample_ready,
	input logic [tctwm_pkg::SAMPLE_W-1:0] tvoc_sample,
	input logic [tctwm_pkg::SAMPLE_W-1:0] eco2_sample,
	input logic                           mean_valid,
	input logic                           mean_ready,
	input logic [tctwm_pkg::SAMPLE_W-1:0] tvoc_mean,
	input logic [tctwm_pkg::SAMPLE_W-1:0] eco2_mean
);

	import tctwm_pkg::*;

	localparam count_t WIN_LAST = CNT_W'(WINDOW - 1);

	count_t     cnt_q;
	logic [2:0] pend_q;
	logic       s_acc, m_acc, closing;

	assign s_acc   = sample_valid && sample_ready;
	assign m_acc   = mean_valid && mean_ready;
	assign closing = s_acc && (cnt_q == WIN_LAST);

	// windows closed but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			pend_q <= '0;
		end else begin
			if (s_acc) cnt_q <= closing ? '0 : cnt_q + CNT_W'(1);
			pend_q <= pend_q + 3'(closing) - 3'(m_acc);
		end
	end

	a_mean_hold: assert property (@(posedge clk) disable iff (!arst_n)
		mean_valid && !mean_ready |=> mean_valid && $stable(tvoc_mean) && $stable(eco2_mean))
		else $error("mean item changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		mean_valid |-> pend_q != 3'd0)
		else $error("mean item without a closed window");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd4)
		else $error("more closed windows in flight than result stages");

	a_ready_mid_window: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != WIN_LAST |-> sample_ready)
		else $error("sample stalled inside a window");

endmodule

bind two_channel_trimmed_window_mean_unit tctwm_checker #(.WINDOW(WINDOW)) u_tctwm_checker (.*);
